>>> sv/nearest_vertex_pick_assert.svh
// assertion helpers for the rtl
`ifndef NEAREST_VERTEX_PICK_ASSERT_SVH
`define NEAREST_VERTEX_PICK_ASSERT_SVH

// same-cycle implication, off during reset
`define NVP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nvp assertion failed");

// next-cycle implication, off during reset
`define NVP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nvp assertion failed");

`endif

>>> sv/nvp_pkg.sv
package nvp_pkg;

	localparam int INDEX_BITS = 12;
	localparam int COORD_W    = 16;
	localparam int DEPTH_W    = 16;
	localparam int WIN_W      = 15;
	localparam int DIST_W     = 33;
	localparam int DX_W       = COORD_W + 1;
	localparam int MY_W       = COORD_W + 2;
	localparam int DY_W       = MY_W;
	localparam int DX2_W      = 2 * DX_W - 2;
	localparam int DY2_W      = 2 * DY_W - 2;
	localparam int SUM_W      = DY2_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIST_W;

	localparam logic signed [COORD_W-1:0] MOUSE_X_RST    = 16'sd5600;
	localparam logic signed [COORD_W-1:0] MOUSE_Y_RST    = 16'sd8736;
	localparam logic [WIN_W-1:0]          WIN_HEIGHT_RST = 15'd9600;
	localparam logic [DIST_W-1:0]         DIST_LIMIT_RST = 33'd256000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOUSE_X       = 2'd0,
		CFG_MOUSE_Y_RAW   = 2'd1,
		CFG_WINDOW_HEIGHT = 2'd2,
		CFG_DIST_LIMIT    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] mouse_x;
		logic signed [MY_W-1:0]    mouse_y;
		logic [DIST_W-1:0]         dist_limit;
	} cfg_t;

	typedef struct packed {
		logic                      valid;
		logic                      last;
		logic [INDEX_BITS-1:0]     index;
		logic signed [DEPTH_W-1:0] depth;
		logic [DX2_W-1:0]          dx2;
		logic [DY2_W-1:0]          dy2;
	} sq_t;

endpackage

>>> sv/nvp_vert_if.sv
interface nvp_vert_if import nvp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [INDEX_BITS-1:0]     vert_index;
	logic signed [COORD_W-1:0] vert_x;
	logic signed [COORD_W-1:0] vert_y;
	logic signed [DEPTH_W-1:0] vert_depth;
	logic                      last_vertex;

	modport source (output valid, vert_index, vert_x, vert_y, vert_depth, last_vertex,
		input ready);
	modport sink (input valid, vert_index, vert_x, vert_y, vert_depth, last_vertex,
		output ready);
endinterface

>>> sv/nvp_pick_if.sv
interface nvp_pick_if import nvp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] match_index;
	logic                  match_found;
	logic [DIST_W-1:0]     match_dist;

	modport source (output valid, match_index, match_found, match_dist, input ready);
	modport sink (input valid, match_index, match_found, match_dist, output ready);
endinterface

>>> sv/nvp_cfg.sv
module nvp_cfg import nvp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic signed [COORD_W-1:0] mouse_x_q;
	logic signed [COORD_W-1:0] mouse_y_raw_q;
	logic [WIN_W-1:0]          win_height_q;
	logic [DIST_W-1:0]         dist_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_x_q     <= MOUSE_X_RST;
			mouse_y_raw_q <= MOUSE_Y_RST;
			win_height_q  <= WIN_HEIGHT_RST;
			dist_limit_q  <= DIST_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MOUSE_X:       mouse_x_q     <= cfg_data[COORD_W-1:0];
				CFG_MOUSE_Y_RAW:   mouse_y_raw_q <= cfg_data[COORD_W-1:0];
				CFG_WINDOW_HEIGHT: win_height_q  <= cfg_data[WIN_W-1:0];
				CFG_DIST_LIMIT:    dist_limit_q  <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// flip mouse y against the window height, full precision
	always_comb begin
		cfg.mouse_x    = mouse_x_q;
		cfg.mouse_y    = $signed({{(MY_W-WIN_W){1'b0}}, win_height_q})
			- $signed({{(MY_W-COORD_W){mouse_y_raw_q[COORD_W-1]}}, mouse_y_raw_q});
		cfg.dist_limit = dist_limit_q;
	end

endmodule

>>> sv/nvp_dist.sv
module nvp_dist import nvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       stall,
	nvp_vert_if.sink   vert,
	output sq_t        sq_s2
);

	logic                      v_s1;
	logic                      last_s1;
	logic [INDEX_BITS-1:0]     index_s1;
	logic signed [COORD_W-1:0] x_s1;
	logic signed [COORD_W-1:0] y_s1;
	logic signed [DEPTH_W-1:0] depth_s1;

	logic                      v_s2;
	logic                      last_s2;
	logic [INDEX_BITS-1:0]     index_s2;
	logic signed [DEPTH_W-1:0] depth_s2;
	logic [DX2_W-1:0]          dx2_s2;
	logic [DY2_W-1:0]          dy2_s2;

	logic signed [DX_W-1:0]   dx;
	logic signed [DY_W-1:0]   dy;
	logic signed [2*DX_W-1:0] dx_sq;
	logic signed [2*DY_W-1:0] dy_sq;

	// s1 may fill while empty even when the tracker stalls
	assign vert.ready = !v_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (vert.ready) begin
			v_s1 <= vert.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vert.ready && vert.valid) begin
			last_s1  <= vert.last_vertex;
			index_s1 <= vert.vert_index;
			x_s1     <= vert.vert_x;
			y_s1     <= vert.vert_y;
			depth_s1 <= vert.vert_depth;
		end
	end

	always_comb begin
		dx    = $signed({cfg.mouse_x[COORD_W-1], cfg.mouse_x})
			- $signed({x_s1[COORD_W-1], x_s1});
		dy    = cfg.mouse_y - $signed({{(DY_W-COORD_W){y_s1[COORD_W-1]}}, y_s1});
		dx_sq = dx * dx;
		dy_sq = dy * dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!stall) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && v_s1) begin
			last_s2  <= last_s1;
			index_s2 <= index_s1;
			depth_s2 <= depth_s1;
			dx2_s2   <= dx_sq[DX2_W-1:0];
			dy2_s2   <= dy_sq[DY2_W-1:0];
		end
	end

	always_comb begin
		sq_s2.valid = v_s2;
		sq_s2.last  = last_s2;
		sq_s2.index = index_s2;
		sq_s2.depth = depth_s2;
		sq_s2.dx2   = dx2_s2;
		sq_s2.dy2   = dy2_s2;
	end

endmodule

>>> sv/nvp_track.sv
`include "nearest_vertex_pick_assert.svh"

module nvp_track import nvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  sq_t        sq_s2,
	output logic       stall,
	nvp_pick_if.source pick
);

	logic                      best_valid_q;
	logic [DIST_W-1:0]         best_dist_q;
	logic signed [DEPTH_W-1:0] best_depth_q;
	logic [INDEX_BITS-1:0]     best_index_q;

	logic                  pick_valid_q;
	logic [INDEX_BITS-1:0] pick_index_q;
	logic                  pick_found_q;
	logic [DIST_W-1:0]     pick_dist_q;

	logic [SUM_W-1:0]  dist_sum;
	logic [DIST_W-1:0] dist33;
	logic              qualify;
	logic              take;
	logic              fire;
	logic              emit;

	logic                      nb_valid;
	logic [DIST_W-1:0]         nb_dist;
	logic signed [DEPTH_W-1:0] nb_depth;
	logic [INDEX_BITS-1:0]     nb_index;

	always_comb begin
		dist_sum = {{(SUM_W-DX2_W){1'b0}}, sq_s2.dx2} + {{(SUM_W-DY2_W){1'b0}}, sq_s2.dy2};
		dist33   = dist_sum[DIST_W-1:0];
		qualify  = dist_sum < {{(SUM_W-DIST_W){1'b0}}, cfg.dist_limit};
		// ties: smaller depth wins, then the earlier vertex stays
		take     = qualify && (!best_valid_q || (dist33 < best_dist_q)
			|| ((dist33 == best_dist_q) && (sq_s2.depth < best_depth_q)));
		nb_valid = best_valid_q || take;
		nb_dist  = take ? dist33 : best_dist_q;
		nb_depth = take ? sq_s2.depth : best_depth_q;
		nb_index = take ? sq_s2.index : best_index_q;
	end

	// only a scan end needs the output register
	assign stall = sq_s2.valid && sq_s2.last && pick_valid_q && !pick.ready;
	assign fire  = sq_s2.valid && !stall;
	assign emit  = fire && sq_s2.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_dist_q  <= '0;
			best_depth_q <= '0;
			best_index_q <= '0;
		end else if (fire) begin
			if (sq_s2.last) begin
				best_valid_q <= 1'b0;
				best_dist_q  <= '0;
				best_depth_q <= '0;
				best_index_q <= '0;
			end else begin
				best_valid_q <= nb_valid;
				best_dist_q  <= nb_dist;
				best_depth_q <= nb_depth;
				best_index_q <= nb_index;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_valid_q <= 1'b0;
		end else if (emit) begin
			pick_valid_q <= 1'b1;
		end else if (pick.ready) begin
			pick_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pick_found_q <= nb_valid;
			pick_index_q <= nb_valid ? nb_index : '0;
			pick_dist_q  <= nb_valid ? nb_dist : '0;
		end
	end

	assign pick.valid       = pick_valid_q;
	assign pick.match_index = pick_index_q;
	assign pick.match_found = pick_found_q;
	assign pick.match_dist  = pick_dist_q;

	`NVP_ASSERT_NOW(a_empty_pick_zero, clk, arst_n, pick_valid_q && !pick_found_q,
		(pick_index_q == '0) && (pick_dist_q == '0))
	`NVP_ASSERT_NOW(a_found_under_limit, clk, arst_n, pick_valid_q && pick_found_q,
		pick_dist_q < cfg.dist_limit)
	`NVP_ASSERT_NXT(a_scan_end_clears, clk, arst_n, emit,
		!best_valid_q && pick_valid_q)

endmodule

>>> sv/nearest_vertex_pick.sv
// channel | dir | handshake     | payload
// vert    | in  | valid / ready | vert_index, vert_x, vert_y, vert_depth, last_vertex
// pick    | out | valid / ready | match_index, match_found, match_dist
// cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// one vertex per cycle unless stalled; a scan end passes s1, s2 and the pick register
// stages: input register, squaring multipliers, add/compare/tracker update
// arst_n clears pipeline valids, the tracker and the config registers to defaults
// a stalled pick only holds the pipe when a scan end reaches the tracker
module nearest_vertex_pick import nvp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	nvp_vert_if.sink              vert,
	nvp_pick_if.source            pick
);

	cfg_t cfg;
	sq_t  sq_s2;
	logic stall;

	nvp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nvp_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.stall  (stall),
		.vert   (vert),
		.sq_s2  (sq_s2)
	);

	nvp_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sq_s2  (sq_s2),
		.stall  (stall),
		.pick   (pick)
	);

endmodule

>>> sim/nearest_vertex_pick_tb.sv
module nearest_vertex_pick_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nvp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [DIST_W-1:0] LIMIT_MAX = '1;

	typedef struct {
		logic [INDEX_BITS-1:0]     idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [DEPTH_W-1:0] depth;
		logic                      last;
	} vertex_t;

	typedef struct {
		logic [INDEX_BITS-1:0] idx;
		logic                  found;
		logic [DIST_W-1:0]     sq_dist;
	} pick_t;

	typedef enum {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, PERIODIC} stall_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	nvp_vert_if vert_ch ();
	nvp_pick_if pick_ch ();

	nearest_vertex_pick uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vert      (vert_ch),
		.pick      (pick_ch)
	);

	// own copy of the registers and the running best
	logic signed [COORD_W-1:0] cur_mouse_x = MOUSE_X_RST;
	logic signed [COORD_W-1:0] cur_mouse_y_raw = MOUSE_Y_RST;
	logic [WIN_W-1:0]          cur_win_h = WIN_HEIGHT_RST;
	logic [DIST_W-1:0]         cur_limit = DIST_LIMIT_RST;
	logic                      best_valid = 1'b0;
	logic [DIST_W-1:0]         best_dist = '0;
	logic signed [DEPTH_W-1:0] best_depth = '0;
	logic [INDEX_BITS-1:0]     best_index = '0;

	pick_t expected_picks[$];
	int    errors = 0;
	int    n_vertices = 0;
	int    n_picks = 0;
	int    n_found = 0;
	int    n_settings = 0;
	int    burst_left = 0;
	int    cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic longint flipped_mouse_y();
		return longint'(cur_win_h) - longint'(cur_mouse_y_raw);
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[COORD_W-1:0];
	endfunction

	function automatic vertex_t mk_vertex(int idx, int x, int y, int depth, int last);
		vertex_t v;
		v.idx = idx[INDEX_BITS-1:0];
		v.x = x[COORD_W-1:0];
		v.y = y[COORD_W-1:0];
		v.depth = depth[DEPTH_W-1:0];
		v.last = last[0];
		return v;
	endfunction

	// running nearest-vertex tracker, emits one expected pick per scan end
	function automatic void track_vertex(vertex_t v);
		longint dx;
		longint dy;
		longint d;
		logic   take;
		pick_t  p;
		dx = longint'(cur_mouse_x) - longint'(v.x);
		dy = flipped_mouse_y() - longint'(v.y);
		d = dx * dx + dy * dy;
		if (d < longint'(cur_limit)) begin
			if (!best_valid)
				take = 1'b1;
			else if (d != longint'(best_dist))
				take = d < longint'(best_dist);
			else
				take = v.depth < best_depth;
			if (take) begin
				best_valid = 1'b1;
				best_dist = d[DIST_W-1:0];
				best_depth = v.depth;
				best_index = v.idx;
			end
		end
		if (v.last) begin
			p.idx = best_valid ? best_index : '0;
			p.found = best_valid;
			p.sq_dist = best_valid ? best_dist : '0;
			expected_picks.insert(expected_picks.size(), p);
			best_valid = 1'b0;
			best_dist = '0;
			best_depth = '0;
			best_index = '0;
		end
	endfunction

	task automatic send_vertex(vertex_t v);
		vert_ch.valid <= 1'b1;
		vert_ch.vert_index <= v.idx;
		vert_ch.vert_x <= v.x;
		vert_ch.vert_y <= v.y;
		vert_ch.vert_depth <= v.depth;
		vert_ch.last_vertex <= v.last;
		@(posedge clk);
		while (!vert_ch.ready)
			@(posedge clk);
		track_vertex(v);
		n_vertices++;
	endtask

	// bursts of random length with random gaps in between
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				vert_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 24);
		end
	endtask

	task automatic send_paced(vertex_t v);
		send_vertex(v);
		pace();
	endtask

	// wait for every pick, then let the pipe empty of non-last vertices
	task automatic drain();
		vert_ch.valid <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= data;
		@(posedge clk);
		case (r)
			CFG_MOUSE_X:       cur_mouse_x = data[COORD_W-1:0];
			CFG_MOUSE_Y_RAW:   cur_mouse_y_raw = data[COORD_W-1:0];
			CFG_WINDOW_HEIGHT: cur_win_h = data[WIN_W-1:0];
			CFG_DIST_LIMIT:    cur_limit = data[DIST_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_regs(logic [CFG_DATA_W-1:0] mx, logic [CFG_DATA_W-1:0] my_raw,
		logic [CFG_DATA_W-1:0] win_h, logic [CFG_DATA_W-1:0] limit);
		write_reg(CFG_MOUSE_X, mx);
		write_reg(CFG_MOUSE_Y_RAW, my_raw);
		write_reg(CFG_WINDOW_HEIGHT, win_h);
		write_reg(CFG_DIST_LIMIT, limit);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// unused upper data bits carry junk that the block must drop
	function automatic logic [CFG_DATA_W-1:0] junk_above(logic [CFG_DATA_W-1:0] v, int w);
		logic [CFG_DATA_W-1:0] r;
		r = CFG_DATA_W'({$urandom, $urandom});
		return (r << w) | v;
	endfunction

	task automatic test_reset_values();
		// mouse sits at (5600, 864) after the flip
		send_paced(mk_vertex(7, 5600, 864, 100, 0));
		send_paced(mk_vertex(9, 5700, 864, -5, 1));
	endtask

	task automatic test_ties_and_limit_edge();
		// four vertices at the same distance: lower depth wins, then the earlier one
		send_paced(mk_vertex(1, 5900, 864, 50, 0));
		send_paced(mk_vertex(2, 5600, 1164, 20, 0));
		send_paced(mk_vertex(3, 5300, 864, 20, 0));
		send_paced(mk_vertex(4, 5600, 564, 20, 1));
		// far away, nothing found
		send_paced(mk_vertex(5, 0, 0, 0, 1));
		// exactly on the limit is out, one below is in
		send_paced(mk_vertex(10, 6080, 1024, 0, 0));
		send_paced(mk_vertex(11, 6080, 1023, 0, 1));
		drain();
	endtask

	task automatic test_extremes();
		write_regs(junk_above(33'h8000, COORD_W), junk_above(33'h8000, COORD_W),
			junk_above(33'h7fff, WIN_W), LIMIT_MAX);
		// distance far past 33 bits is ignored
		send_paced(mk_vertex(4095, 32767, -32768, 32767, 0));
		send_paced(mk_vertex(0, -32768, 32767, -32768, 1));
		// distance just under the top of the limit
		send_paced(mk_vertex('h555, 32767, 0, -1, 1));
		drain();
	endtask

	task automatic test_zero_limit();
		write_regs(junk_above(33'h7fff, COORD_W), junk_above(33'h7fff, COORD_W), 33'd0, 33'd0);
		send_paced(mk_vertex(1, 32767, -32767, 0, 1));
		drain();
		write_regs(33'h7fff, 33'h7fff, 33'd0, 33'd1);
		send_paced(mk_vertex('haaa, 32767, -32767, 0, 1));
		drain();
	endtask

	task automatic random_scan(int spread);
		int          len;
		bit          ties;
		logic [31:0] r;
		vertex_t     v;
		longint      cx;
		longint      cy;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
		ties = ($urandom_range(0, 2) == 0);
		cx = longint'(cur_mouse_x);
		cy = longint'(clamp_coord(flipped_mouse_y()));
		for (int i = 0; i < len; i++) begin
			r = $urandom;
			v.idx = r[INDEX_BITS-1:0];
			v.last = (i == len - 1);
			if ($urandom_range(0, 6) == 0) begin
				// noise, may also cut the scan short
				v.x = r[31:16];
				r = $urandom;
				v.y = r[15:0];
				v.depth = r[31:16];
				v.last = v.last | ($urandom_range(0, 7) == 0);
			end else if (ties) begin
				v.x = clamp_coord(cx + longint'($urandom_range(0, 6)) - 3);
				v.y = clamp_coord(cy + longint'($urandom_range(0, 6)) - 3);
				v.depth = DEPTH_W'(int'($urandom_range(0, 4)) - 2);
			end else begin
				v.x = clamp_coord(cx + longint'($urandom_range(0, 2 * spread)) - spread);
				v.y = clamp_coord(cy + longint'($urandom_range(0, 2 * spread)) - spread);
				r = $urandom;
				v.depth = r[15:0];
			end
			send_paced(v);
		end
	endtask

	task automatic test_random_scans();
		int     start;
		int     spread;
		int     pick;
		longint lim;
		logic [31:0] r;
		logic [CFG_DATA_W-1:0] mx;
		logic [CFG_DATA_W-1:0] win_h;
		logic [CFG_DATA_W-1:0] limit;
		start = n_vertices;
		while (n_vertices - start < RANDOM_ITEMS) begin
			drain();
			case ($urandom_range(0, 4))
				0: spread = 3;
				1: spread = 40;
				2: spread = 700;
				3: spread = 20000;
				default: spread = 60000;
			endcase
			r = $urandom;
			mx = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'(r[15:0])
				: CFG_DATA_W'(int'($urandom_range(0, 4000)) - 2000);
			case ($urandom_range(0, 3))
				0: win_h = 33'd0;
				1: win_h = 33'h7fff;
				default: win_h = CFG_DATA_W'($urandom_range(0, 32767));
			endcase
			pick = $urandom_range(0, 9);
			lim = longint'(spread) * spread * $urandom_range(25, 300) / 100;
			if (pick == 0)
				limit = 33'd0;
			else if (pick == 1)
				limit = LIMIT_MAX;
			else if (pick == 2)
				limit = {1'($urandom_range(0, 1)), $urandom};
			else
				limit = (lim > longint'(LIMIT_MAX)) ? LIMIT_MAX : lim[DIST_W-1:0];
			write_regs(junk_above(mx, COORD_W),
				junk_above(CFG_DATA_W'($urandom_range(0, 65535)), COORD_W),
				junk_above(win_h, WIN_W), limit);
			repeat ($urandom_range(6, 14))
				random_scan(spread);
		end
		drain();
	endtask

	// receiver stalls, in a pattern picked anew at random
	initial begin
		stall_mode_t mode;
		int          left;
		int          phase;
		mode = ALWAYS_READY;
		left = 0;
		phase = 0;
		pick_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 300);
			end
			left--;
			phase++;
			case (mode)
				ALWAYS_READY:   pick_ch.ready <= 1'b1;
				COIN_FLIP:      pick_ch.ready <= 1'($urandom_range(0, 1));
				MOSTLY_STALLED: pick_ch.ready <= ($urandom_range(0, 4) == 0);
				default:        pick_ch.ready <= (phase % 9) < 4;
			endcase
		end
	end

	always @(posedge clk) begin
		pick_t exp_pick;
		if (arst_n && pick_ch.valid && pick_ch.ready) begin
			if (expected_picks.size() == 0) begin
				$error("pick transaction with nothing expected: index %0d found %0d dist %0d",
					pick_ch.match_index, pick_ch.match_found, pick_ch.match_dist);
				errors++;
			end else begin
				exp_pick = expected_picks.pop_front();
				n_picks++;
				if (exp_pick.found)
					n_found++;
				if (pick_ch.match_index !== exp_pick.idx) begin
					$error("match_index: expected %0d, got %0d", exp_pick.idx,
						pick_ch.match_index);
					errors++;
				end
				if (pick_ch.match_found !== exp_pick.found) begin
					$error("match_found: expected %0d, got %0d", exp_pick.found,
						pick_ch.match_found);
					errors++;
				end
				if (pick_ch.match_dist !== exp_pick.sq_dist) begin
					$error("match_dist: expected %0d, got %0d", exp_pick.sq_dist,
						pick_ch.match_dist);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MOUSE_X;
		cfg_data <= '0;
		vert_ch.valid <= 1'b0;
		vert_ch.vert_index <= '0;
		vert_ch.vert_x <= '0;
		vert_ch.vert_y <= '0;
		vert_ch.vert_depth <= '0;
		vert_ch.last_vertex <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_ties_and_limit_edge();
		test_extremes();
		test_zero_limit();
		test_random_scans();

		if (expected_picks.size() != 0) begin
			$error("%0d expected picks never arrived", expected_picks.size());
			errors++;
		end
		$display("sent %0d vertices under %0d register settings plus reset defaults",
			n_vertices, n_settings);
		$display("compared %0d picks, %0d with a vertex found, %0d mismatches",
			n_picks, n_found, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
